// ----- rtl/lprt_pkg.sv -----
// Shared types, constants and the arctangent table for the lidar ring and time block.
`timescale 1ns / 1ps
`default_nettype none
package lprt_pkg;

	localparam logic [1:0] CFG_BOTTOM  = 2'd0;
	localparam logic [1:0] CFG_SPACING = 2'd1;
	localparam logic [1:0] CFG_RATE    = 2'd2;

	localparam logic [14:0] BOTTOM_RST  = 15'd3866;
	localparam logic [14:0] SPACING_RST = 15'd512;
	localparam logic [5:0]  RATE_RST    = 6'd10;

	localparam logic [4:0]         CORDIC_LAST = 5'd22;
	localparam logic signed [16:0] HALF_TURN   = 17'sd46080;
	localparam logic signed [24:0] QUARTER     = 25'sd23040;
	localparam logic signed [17:0] FULL_TURN   = 18'sd92160;
	localparam logic [19:0]        TIME_MAX    = 20'hFFFFF;
	localparam logic [16:0]        DEN_UNIT    = 17'd92416;
	localparam logic [19:0]        US_SCALE    = 20'd1000000;
	localparam logic [5:0]         RING_STEPS  = 6'd16;
	localparam logic [5:0]         TIME_STEPS  = 6'd37;

	typedef enum logic [3:0] {
		ST_IDLE, ST_MUL_X, ST_MUL_Y, ST_SQRT_GO, ST_SQRT_RUN, ST_EL_GO, ST_EL_RUN,
		ST_RING_GO, ST_RING_RUN, ST_YAW_GO, ST_YAW_RUN, ST_TIME_MUL, ST_TIME_GO,
		ST_TIME_RUN, ST_OUT
	} ctrl_state_t;

	typedef enum logic [1:0] {CP_IDLE, CP_NORM, CP_ITER, CP_FIN} cordic_phase_t;

	typedef struct packed {
		logic load;
		logic mul_x;
		logic mul_y;
		logic sqrt_start;
		logic cordic_start;
		logic cordic_yaw;
		logic div_start;
		logic div_time;
		logic ring_latch;
		logic first_wr;
		logic time_mul;
		logic time_latch;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic sqrt_done;
		logic cordic_done;
		logic div_done;
		logic keep;
		logic unseen;
		logic out_free;
	} sts_t;

	// atan(2^-i) in 2^-16 degree
	function automatic logic [21:0] cordic_atan(input logic [4:0] i);
		logic [21:0] v;
		case (i)
			5'd0:  v = 22'd2949120;
			5'd1:  v = 22'd1740967;
			5'd2:  v = 22'd919879;
			5'd3:  v = 22'd466945;
			5'd4:  v = 22'd234379;
			5'd5:  v = 22'd117304;
			5'd6:  v = 22'd58666;
			5'd7:  v = 22'd29335;
			5'd8:  v = 22'd14668;
			5'd9:  v = 22'd7334;
			5'd10: v = 22'd3667;
			5'd11: v = 22'd1833;
			5'd12: v = 22'd917;
			5'd13: v = 22'd458;
			5'd14: v = 22'd229;
			5'd15: v = 22'd115;
			5'd16: v = 22'd57;
			5'd17: v = 22'd29;
			5'd18: v = 22'd14;
			5'd19: v = 22'd7;
			5'd20: v = 22'd4;
			5'd21: v = 22'd2;
			5'd22: v = 22'd1;
			default: v = 22'd0;
		endcase
		return v;
	endfunction

endpackage
`default_nettype wire

// ----- rtl/lprt_cordic.sv -----
// Iterative atan2 unit: normalise, 23 vectoring steps, round and fold to quadrant.
`timescale 1ns / 1ps
`default_nettype none
module lprt_cordic (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic signed [32:0] yv,
	input  wire logic signed [32:0] xv,
	output logic signed [16:0]      angle,
	output logic                    done
);
	import lprt_pkg::*;

	cordic_phase_t      ph_q;
	logic signed [43:0] cx_q, cy_q;
	logic signed [24:0] acc_q;
	logic [4:0]         i_q;
	logic               xneg_q, yneg_q, done_q;
	logic signed [16:0] ang_q;

	logic signed [43:0] xe, ye, ax, ay, dx, dy;
	logic signed [24:0] tr, tab;
	logic signed [16:0] tc, tm;
	logic               small8, under40;

	always_comb begin
		xe = 44'(xv);
		ye = 44'(yv);
		ax = xe[43] ? -xe : xe;
		ay = ye[43] ? -ye : ye;
		dx = cy_q >>> i_q;
		dy = cx_q >>> i_q;
		tab = $signed({3'b000, cordic_atan(i_q)});
		tr = (acc_q + 25'sd128) >>> 8;
		if (tr < 25'sd0)
			tc = 17'sd0;
		else if (tr > QUARTER)
			tc = 17'(QUARTER);
		else
			tc = tr[16:0];
		tm = xneg_q ? HALF_TURN - tc : tc;
		if (yneg_q)
			tm = -tm;
		under40 = (cx_q[43:40] == 4'd0) && (cy_q[43:40] == 4'd0);
		small8  = (cx_q[43:32] == 12'd0) && (cy_q[43:32] == 12'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q   <= CP_IDLE;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (ph_q)
				CP_IDLE: begin
					if (start)
						ph_q <= ((ax == 44'sd0) && (ay == 44'sd0)) ? CP_ITER : CP_NORM;
				end
				CP_NORM: begin
					if (!under40)
						ph_q <= CP_ITER;
				end
				CP_ITER: begin
					if (i_q == CORDIC_LAST)
						ph_q <= CP_FIN;
				end
				CP_FIN: begin
					ph_q   <= CP_IDLE;
					done_q <= 1'b1;
				end
				default: ph_q <= CP_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (ph_q)
			CP_IDLE: begin
				if (start) begin
					cx_q   <= ax;
					cy_q   <= ay;
					acc_q  <= 25'sd0;
					i_q    <= 5'd0;
					xneg_q <= xv[32];
					yneg_q <= yv[32];
				end
			end
			CP_NORM: begin
				if (under40) begin
					cx_q <= small8 ? cx_q <<< 8 : cx_q <<< 1;
					cy_q <= small8 ? cy_q <<< 8 : cy_q <<< 1;
				end
			end
			CP_ITER: begin
				if (cy_q > 44'sd0) begin
					cx_q  <= cx_q + dx;
					cy_q  <= cy_q - dy;
					acc_q <= acc_q + tab;
				end else begin
					cx_q  <= cx_q - dx;
					cy_q  <= cy_q + dy;
					acc_q <= acc_q - tab;
				end
				i_q <= i_q + 5'd1;
			end
			CP_FIN: ang_q <= tm;
			default: ;
		endcase
	end

	assign angle = ang_q;
	assign done  = done_q;

endmodule
`default_nettype wire

// ----- rtl/lprt_div.sv -----
// Restoring divider, one quotient bit a cycle, shared by ring and time.
`timescale 1ns / 1ps
`default_nettype none
module lprt_div (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [39:0] num,
	input  wire logic [23:0] den,
	input  wire logic [5:0]  steps,
	output logic [39:0]      quo,
	output logic             done
);
	import lprt_pkg::*;

	logic [39:0] num_q;
	logic [23:0] rem_q, den_q;
	logic [5:0]  cnt_q;
	logic        busy_q, done_q;
	logic [24:0] trial;
	logic        ge;

	always_comb begin
		trial = {rem_q, num_q[39]};
		ge    = trial >= {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && cnt_q == 6'd1) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= 24'd0;
			cnt_q <= steps;
		end else if (busy_q) begin
			rem_q <= ge ? 24'(trial - {1'b0, den_q}) : trial[23:0];
			num_q <= {num_q[38:0], ge};
			cnt_q <= cnt_q - 6'd1;
		end
	end

	assign quo  = num_q;
	assign done = done_q;

endmodule
`default_nettype wire

// ----- rtl/lprt_datapath.sv -----
// Datapath: registers, squares, root, atan2 and divide units, ring state and result register.
`timescale 1ns / 1ps
`default_nettype none
module lprt_datapath #(
	parameter int RING_COUNT = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire lprt_pkg::cmd_t     cmd,
	output lprt_pkg::sts_t          sts,
	input  wire logic               cfg_we,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [14:0]        cfg_data,
	input  wire logic               frame_start,
	input  wire logic signed [31:0] pos_x,
	input  wire logic signed [31:0] pos_y,
	input  wire logic signed [31:0] pos_z,
	input  wire logic [31:0]        intensity_raw,
	input  wire logic               out_stall,
	output logic                    out_valid,
	output logic                    keep,
	output logic [6:0]              ring,
	output logic [19:0]             time_us,
	output logic signed [31:0]      out_x,
	output logic signed [31:0]      out_y,
	output logic signed [31:0]      out_z,
	output logic [31:0]             out_intensity
);
	import lprt_pkg::*;

	localparam int RW = (RING_COUNT > 1) ? $clog2(RING_COUNT) : 1;

	logic [14:0] bottom_q, spacing_q;
	logic [5:0]  rate_q;

	logic signed [31:0] x_q, y_q, z_q, ox_q, oy_q, oz_q;
	logic [31:0]        int_q, oint_q;
	logic [63:0]        p_q, sq_q, v_q, res_q, bit_q;
	logic               sq_busy_q;
	logic               sum_neg_q, keep_q, okeep_q, out_valid_q;
	logic [RW-1:0]      ring_q;
	logic [6:0]         oring_q;
	logic [19:0]        time_q, otime_q;
	logic [RING_COUNT-1:0] unseen_q;
	logic signed [16:0] yaw_mem [RING_COUNT];
	logic signed [16:0] first_rd_q;
	logic [36:0]        dm_q;
	logic [22:0]        den_q;

	logic signed [31:0] mop;
	logic signed [63:0] prod;
	logic [63:0]        trial;
	logic signed [32:0] c_y, c_x;
	logic signed [16:0] angle;
	logic               c_done;
	logic signed [17:0] sum, diff;
	logic [15:0]        sum_abs;
	logic [39:0]        d_num, quo;
	logic [23:0]        d_den;
	logic [5:0]         d_steps;
	logic               d_done, keep_c;
	logic [14:0]        sp_eff;
	logic [5:0]         rate_eff;
	logic [36:0]        tnum;

	always_comb begin
		mop      = cmd.mul_y ? y_q : x_q;
		prod     = mop * mop;
		trial    = res_q + bit_q;
		sp_eff   = (spacing_q == 15'd0) ? 15'd1 : spacing_q;
		rate_eff = (rate_q == 6'd0) ? 6'd1 : rate_q;
		c_y      = cmd.cordic_yaw ? 33'(y_q) : 33'(z_q);
		c_x      = cmd.cordic_yaw ? 33'(x_q) : $signed({1'b0, res_q[31:0]});
		sum      = 18'(angle) + $signed({3'b000, bottom_q});
		sum_abs  = sum[17] ? 16'(-sum) : sum[15:0];
		tnum     = dm_q + 37'(den_q >> 1);
		d_num    = cmd.div_time ? {tnum, 3'b000} : {sum_abs, 24'd0};
		d_den    = cmd.div_time ? {1'b0, den_q} : {9'd0, sp_eff};
		d_steps  = cmd.div_time ? TIME_STEPS : RING_STEPS;
		keep_c   = sum_neg_q ? (quo == 40'd0) : (quo < 40'(RING_COUNT));
		diff     = 18'(first_rd_q) - 18'(angle);
		if (angle > first_rd_q)
			diff = diff + FULL_TURN;
	end

	lprt_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.cordic_start),
		.yv     (c_y),
		.xv     (c_x),
		.angle  (angle),
		.done   (c_done)
	);

	lprt_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (d_num),
		.den    (d_den),
		.steps  (d_steps),
		.quo    (quo),
		.done   (d_done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bottom_q    <= BOTTOM_RST;
			spacing_q   <= SPACING_RST;
			rate_q      <= RATE_RST;
			sq_busy_q   <= 1'b0;
			out_valid_q <= 1'b0;
			unseen_q    <= '1;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_BOTTOM:  bottom_q  <= cfg_data;
					CFG_SPACING: spacing_q <= cfg_data;
					CFG_RATE:    rate_q    <= cfg_data[5:0];
					default: ;
				endcase
			end
			if (cmd.sqrt_start)
				sq_busy_q <= 1'b1;
			else if (sq_busy_q && bit_q[0])
				sq_busy_q <= 1'b0;
			if (cmd.load && frame_start)
				unseen_q <= '1;
			else if (cmd.first_wr)
				unseen_q[ring_q] <= 1'b0;
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q    <= pos_x;
			y_q    <= pos_y;
			z_q    <= pos_z;
			int_q  <= intensity_raw;
			keep_q <= 1'b0;
			ring_q <= '0;
			time_q <= 20'd0;
		end
		if (cmd.mul_x || cmd.mul_y)
			p_q <= prod;
		if (cmd.mul_y)
			sq_q <= p_q;
		if (cmd.sqrt_start) begin
			v_q   <= sq_q + p_q;
			res_q <= 64'd0;
			bit_q <= 64'd1 << 62;
		end else if (sq_busy_q) begin
			if (v_q >= trial) begin
				v_q   <= v_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
		if (cmd.div_start && !cmd.div_time)
			sum_neg_q <= sum[17];
		if (cmd.ring_latch) begin
			ring_q <= quo[RW-1:0];
			keep_q <= keep_c;
		end
		if (cmd.first_wr)
			yaw_mem[ring_q] <= angle;
		first_rd_q <= yaw_mem[ring_q];
		if (cmd.time_mul) begin
			dm_q  <= 37'(diff[16:0]) * 37'(US_SCALE);
			den_q <= 23'(DEN_UNIT) * 23'(rate_eff);
		end
		if (cmd.time_latch)
			time_q <= (quo > 40'(TIME_MAX)) ? TIME_MAX : quo[19:0];
		if (cmd.out_load) begin
			okeep_q <= keep_q;
			oring_q <= keep_q ? 7'(ring_q) : 7'd0;
			otime_q <= time_q;
			ox_q    <= x_q;
			oy_q    <= y_q;
			oz_q    <= z_q;
			oint_q  <= int_q;
		end
	end

	always_comb begin
		sts.sqrt_done   = sq_busy_q && bit_q[0];
		sts.cordic_done = c_done;
		sts.div_done    = d_done;
		sts.keep        = keep_c;
		sts.unseen      = unseen_q[ring_q];
		sts.out_free    = !out_valid_q || !out_stall;
	end

	assign out_valid     = out_valid_q;
	assign keep          = okeep_q;
	assign ring          = oring_q;
	assign time_us       = otime_q;
	assign out_x         = ox_q;
	assign out_y         = oy_q;
	assign out_z         = oz_q;
	assign out_intensity = oint_q;

endmodule
`default_nettype wire

// ----- rtl/lprt_ctrl.sv -----
// Controller state machine sequencing one point through the datapath.
`timescale 1ns / 1ps
`default_nettype none
module lprt_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_stall,
	input  wire lprt_pkg::sts_t sts,
	output lprt_pkg::cmd_t      cmd
);
	import lprt_pkg::*;

	ctrl_state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_nx;
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE:     if (in_valid) state_nx = ST_MUL_X;
			ST_MUL_X:    state_nx = ST_MUL_Y;
			ST_MUL_Y:    state_nx = ST_SQRT_GO;
			ST_SQRT_GO:  state_nx = ST_SQRT_RUN;
			ST_SQRT_RUN: if (sts.sqrt_done) state_nx = ST_EL_GO;
			ST_EL_GO:    state_nx = ST_EL_RUN;
			ST_EL_RUN:   if (sts.cordic_done) state_nx = ST_RING_GO;
			ST_RING_GO:  state_nx = ST_RING_RUN;
			ST_RING_RUN: if (sts.div_done) state_nx = sts.keep ? ST_YAW_GO : ST_OUT;
			ST_YAW_GO:   state_nx = ST_YAW_RUN;
			ST_YAW_RUN:  if (sts.cordic_done) state_nx = sts.unseen ? ST_OUT : ST_TIME_MUL;
			ST_TIME_MUL: state_nx = ST_TIME_GO;
			ST_TIME_GO:  state_nx = ST_TIME_RUN;
			ST_TIME_RUN: if (sts.div_done) state_nx = ST_OUT;
			ST_OUT:      if (sts.out_free) state_nx = ST_IDLE;
			default:     state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_stall = (state_q != ST_IDLE);
		case (state_q)
			ST_IDLE:     cmd.load = in_valid;
			ST_MUL_X:    cmd.mul_x = 1'b1;
			ST_MUL_Y:    cmd.mul_y = 1'b1;
			ST_SQRT_GO:  cmd.sqrt_start = 1'b1;
			ST_EL_GO:    cmd.cordic_start = 1'b1;
			ST_RING_GO:  cmd.div_start = 1'b1;
			ST_RING_RUN: cmd.ring_latch = sts.div_done;
			ST_YAW_GO: begin
				cmd.cordic_start = 1'b1;
				cmd.cordic_yaw   = 1'b1;
			end
			ST_YAW_RUN:  cmd.first_wr = sts.cordic_done && sts.unseen;
			ST_TIME_MUL: cmd.time_mul = 1'b1;
			ST_TIME_GO: begin
				cmd.div_start = 1'b1;
				cmd.div_time  = 1'b1;
			end
			ST_TIME_RUN: begin
				cmd.div_time   = 1'b1;
				cmd.time_latch = sts.div_done;
			end
			ST_OUT:      cmd.out_load = sts.out_free;
			default: ;
		endcase
	end

endmodule
`default_nettype wire

// ----- rtl/lidar_point_ring_and_time_top.sv -----
// Top level of the lidar ring index and point time block.
//
//  channel | direction | handshake              | payload
//  in      | input     | in_valid / in_stall    | frame_start, pos_x/y/z, intensity_raw
//  out     | output    | out_valid / out_stall  | keep, ring, time_us, out_x/y/z, out_intensity
//  cfg     | input     | cfg_we                 | cfg_index, cfg_data
//
// One point at a time: a new request is taken only once the last result has been loaded,
// and that load waits while out_stall holds a full output register.
// The 32-step root, the two CORDIC passes and the shared bit-serial divider carry the work.
// A finished result sits in the output register while the next request is taken.
// Reset clears control, restores register defaults and marks every ring unseen;
// the first-yaw memory needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module lidar_point_ring_and_time_top #(
	parameter int RING_COUNT = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [14:0]        cfg_data,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic               frame_start,
	input  wire logic signed [31:0] pos_x,
	input  wire logic signed [31:0] pos_y,
	input  wire logic signed [31:0] pos_z,
	input  wire logic [31:0]        intensity_raw,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic                    keep,
	output logic [6:0]              ring,
	output logic [19:0]             time_us,
	output logic signed [31:0]      out_x,
	output logic signed [31:0]      out_y,
	output logic signed [31:0]      out_z,
	output logic [31:0]             out_intensity
);
	import lprt_pkg::*;

	cmd_t cmd;
	sts_t sts;

	lprt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	lprt_datapath #(
		.RING_COUNT (RING_COUNT)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.frame_start   (frame_start),
		.pos_x         (pos_x),
		.pos_y         (pos_y),
		.pos_z         (pos_z),
		.intensity_raw (intensity_raw),
		.out_stall     (out_stall),
		.out_valid     (out_valid),
		.keep          (keep),
		.ring          (ring),
		.time_us       (time_us),
		.out_x         (out_x),
		.out_y         (out_y),
		.out_z         (out_z),
		.out_intensity (out_intensity)
	);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("controller idle after request taken");

	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> sts.out_free)
		else $error("result register overwritten");

	a_one_start: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.sqrt_start, cmd.cordic_start, cmd.div_start, cmd.load}))
		else $error("two units started together");

	a_first_wr: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.first_wr |-> (sts.unseen && !cmd.time_mul))
		else $error("first yaw written for a seen ring");

endmodule
`default_nettype wire
